// ===== hw/rtl/tlbpt_pkg.sv =====
package tlbpt_pkg;

    localparam int ADDR_W      = 16;
    localparam int FRAME_OUT_W = 8;
    localparam int CNT_W       = 16;

    localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

    // commands from the controller to the datapath
    typedef struct packed {
        logic clear_wr;
        logic load;
        logic commit;
    } t_ctrl_cmd;

    // status from the datapath to the controller
    typedef struct packed {
        logic clear_done;
        logic out_free;
    } t_ctrl_sts;

endpackage

// ===== hw/rtl/tlbpt_ram.sv =====
module tlbpt_ram #(
    parameter int WIDTH = 9,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== hw/rtl/tlbpt_ctrl.sv =====
module tlbpt_ctrl (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_stall,
    input  tlbpt_pkg::t_ctrl_sts  i_sts,
    output tlbpt_pkg::t_ctrl_cmd  o_cmd
);

    localparam logic [1:0] S_CLEAR = 2'd0;
    localparam logic [1:0] S_IDLE  = 2'd1;
    localparam logic [1:0] S_LOOK  = 2'd2;

    logic [1:0] r_state;
    logic [1:0] n_state;

    always_comb begin
        o_cmd.clear_wr = (r_state == S_CLEAR);
        o_cmd.load     = (r_state == S_IDLE) && i_valid;
        o_cmd.commit   = (r_state == S_LOOK) && i_sts.out_free;
    end

    assign o_stall = (r_state != S_IDLE);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_CLEAR: begin
                if (i_sts.clear_done) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_valid) begin
                    n_state = S_LOOK;
                end
            end
            S_LOOK: begin
                if (i_sts.out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_CLEAR;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

// ===== hw/rtl/tlbpt_dpath.sv =====
module tlbpt_dpath #(
    parameter int TLB_DEPTH   = 16,
    parameter int PAGE_COUNT  = 256,
    parameter int FRAME_COUNT = 256,
    parameter int OFFSET_BITS = 8
) (
    input  logic                                      i_clk,
    input  logic                                      i_rst_n,
    input  tlbpt_pkg::t_ctrl_cmd                      i_cmd,
    output tlbpt_pkg::t_ctrl_sts                      o_sts,
    input  logic [tlbpt_pkg::ADDR_W-1:0]              i_logical_address,
    input  logic                                      i_out_stall,
    output logic                                      o_out_valid,
    output logic [tlbpt_pkg::ADDR_W-1:0]              o_physical_address,
    output logic [tlbpt_pkg::FRAME_OUT_W-1:0]         o_frame_index,
    output logic                                      o_tlb_hit,
    output logic                                      o_page_fault,
    output logic [tlbpt_pkg::CNT_W-1:0]               o_fault_count,
    output logic [tlbpt_pkg::CNT_W-1:0]               o_hit_count
);

    localparam int PAGE_W    = $clog2(PAGE_COUNT);
    localparam int FRAME_W   = $clog2(FRAME_COUNT);
    localparam int TLB_IDX_W = $clog2(TLB_DEPTH);
    localparam int MAP_W     = FRAME_W + 1;

    // input address and the page it names
    logic [tlbpt_pkg::ADDR_W-1:0] r_addr;
    logic [tlbpt_pkg::ADDR_W-1:0] in_page_raw;
    logic [tlbpt_pkg::ADDR_W-1:0] cur_page_raw;
    logic [PAGE_W-1:0]            in_page;
    logic [PAGE_W-1:0]            cur_page;

    // tlb entries
    logic [PAGE_W-1:0]    r_tlb_tag   [TLB_DEPTH];
    logic [FRAME_W-1:0]   r_tlb_frame [TLB_DEPTH];
    logic [TLB_DEPTH-1:0] r_tlb_valid;
    logic [TLB_IDX_W-1:0] r_tlb_ptr;
    logic [TLB_IDX_W-1:0] n_tlb_ptr;

    // page table, valid bit above the frame
    logic                 map_wr_en;
    logic [PAGE_W-1:0]    map_wr_addr;
    logic [MAP_W-1:0]     map_wr_data;
    logic [PAGE_W-1:0]    map_rd_addr;
    logic [MAP_W-1:0]     map_rd_data;
    logic [PAGE_W-1:0]    r_clr_addr;

    logic [FRAME_W-1:0]   r_next_frame;
    logic [FRAME_W-1:0]   n_next_frame;
    logic [tlbpt_pkg::CNT_W-1:0] r_faults;
    logic [tlbpt_pkg::CNT_W-1:0] r_hits;
    logic [tlbpt_pkg::CNT_W-1:0] n_faults;
    logic [tlbpt_pkg::CNT_W-1:0] n_hits;

    logic                 tlb_hit;
    logic [FRAME_W-1:0]   tlb_frame;
    logic                 map_hit;
    logic                 fault;
    logic [FRAME_W-1:0]   frame;
    logic [31:0]          pa_wide;

    logic                              r_out_valid;
    logic [tlbpt_pkg::ADDR_W-1:0]      r_pa;
    logic [tlbpt_pkg::FRAME_OUT_W-1:0] r_frame_out;
    logic                              r_hit;
    logic                              r_fault;

    // page count is a power of two, so the modulo is a mask
    assign in_page_raw  = i_logical_address >> OFFSET_BITS;
    assign cur_page_raw = r_addr >> OFFSET_BITS;
    assign in_page      = in_page_raw[PAGE_W-1:0];
    assign cur_page     = cur_page_raw[PAGE_W-1:0];

    // lowest matching valid entry wins
    always_comb begin
        tlb_hit   = 1'b0;
        tlb_frame = '0;
        for (int i = TLB_DEPTH - 1; i >= 0; i--) begin
            if (r_tlb_valid[i] && (r_tlb_tag[i] == cur_page)) begin
                tlb_hit   = 1'b1;
                tlb_frame = r_tlb_frame[i];
            end
        end
    end

    assign map_hit = map_rd_data[FRAME_W];
    assign fault   = !tlb_hit && !map_hit;

    always_comb begin
        if (tlb_hit) begin
            frame = tlb_frame;
        end else if (map_hit) begin
            frame = map_rd_data[FRAME_W-1:0];
        end else begin
            frame = r_next_frame;
        end
    end

    assign pa_wide = (32'(frame) << OFFSET_BITS)
                   | (32'(r_addr) & ((32'd1 << OFFSET_BITS) - 32'd1));

    assign n_next_frame = (r_next_frame == FRAME_W'(FRAME_COUNT - 1))
                        ? '0 : r_next_frame + 1'b1;
    assign n_tlb_ptr    = (r_tlb_ptr == TLB_IDX_W'(TLB_DEPTH - 1))
                        ? '0 : r_tlb_ptr + 1'b1;
    assign n_faults     = (r_faults == tlbpt_pkg::CNT_MAX) ? r_faults : r_faults + 1'b1;
    assign n_hits       = (r_hits == tlbpt_pkg::CNT_MAX) ? r_hits : r_hits + 1'b1;

    // clearing sweep after reset, then fault write-back
    assign map_wr_en   = i_cmd.clear_wr || (i_cmd.commit && fault);
    assign map_wr_addr = i_cmd.clear_wr ? r_clr_addr : cur_page;
    assign map_wr_data = i_cmd.clear_wr ? '0 : {1'b1, r_next_frame};
    assign map_rd_addr = i_cmd.load ? in_page : cur_page;

    tlbpt_ram #(
        .WIDTH (MAP_W),
        .DEPTH (PAGE_COUNT)
    ) u_map_ram (
        .i_clk     (i_clk),
        .i_wr_en   (map_wr_en),
        .i_wr_addr (map_wr_addr),
        .i_wr_data (map_wr_data),
        .i_rd_addr (map_rd_addr),
        .o_rd_data (map_rd_data)
    );

    always_comb begin
        o_sts.clear_done = (r_clr_addr == PAGE_W'(PAGE_COUNT - 1));
        o_sts.out_free   = !r_out_valid || !i_out_stall;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_addr   <= '0;
            r_tlb_valid  <= '0;
            r_tlb_ptr    <= '0;
            r_next_frame <= '0;
            r_faults     <= '0;
            r_hits       <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cmd.clear_wr) begin
                r_clr_addr <= r_clr_addr + 1'b1;
            end
            if (i_cmd.commit) begin
                r_out_valid <= 1'b1;
                if (tlb_hit) begin
                    r_hits <= n_hits;
                end
                if (fault) begin
                    r_faults               <= n_faults;
                    r_next_frame           <= n_next_frame;
                    r_tlb_valid[r_tlb_ptr] <= 1'b1;
                    r_tlb_ptr              <= n_tlb_ptr;
                end
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_addr <= i_logical_address;
        end
        if (i_cmd.commit) begin
            r_pa        <= pa_wide[tlbpt_pkg::ADDR_W-1:0];
            r_frame_out <= tlbpt_pkg::FRAME_OUT_W'(frame);
            r_hit       <= tlb_hit;
            r_fault     <= fault;
            if (fault) begin
                r_tlb_tag[r_tlb_ptr]   <= cur_page;
                r_tlb_frame[r_tlb_ptr] <= r_next_frame;
            end
        end
    end

    assign o_out_valid        = r_out_valid;
    assign o_physical_address = r_pa;
    assign o_frame_index      = r_frame_out;
    assign o_tlb_hit          = r_hit;
    assign o_page_fault       = r_fault;
    assign o_fault_count      = r_faults;
    assign o_hit_count        = r_hits;

`ifndef SYNTHESIS
    a_hit_fault_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> !(r_hit && r_fault))
        else $error("result marked both tlb hit and page fault");

    a_commit_slot_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.commit |-> (!r_out_valid || !i_out_stall))
        else $error("result written over a word still waiting");

    a_fault_fills_tlb: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.commit && fault) |=> r_tlb_valid[$past(r_tlb_ptr)])
        else $error("page fault did not fill the tlb slot");

    a_fault_moves_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.commit && fault) |=> (r_next_frame != $past(r_next_frame)))
        else $error("page fault did not advance the frame pointer");

    a_no_load_in_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.clear_wr |-> !(i_cmd.load || i_cmd.commit))
        else $error("item handled during page table clear");
`endif

endmodule

// ===== hw/rtl/tlb_page_table_translator_core.sv =====
// Paged address translator with a fully associative TLB refilled in FIFO order.
// Each accepted word is a logical address: the bits above OFFSET_BITS give the
// page (PAGE_COUNT must be a power of two), the low bits the offset. The page
// is compared against all TLB entries at once; on a miss the page table RAM
// answers, and an unmapped page takes the next frame round-robin, which is
// written back to the page table and into the TLB slot under the FIFO pointer.
// Each word yields one result with physical address, frame, hit and fault
// flags and saturating fault and hit totals. Each item goes through the
// registered read of the page table RAM, then the lookup is resolved and the
// write-back made; a new word is taken only once the previous result is in
// the output register. After reset every entry of the page table is swept
// clear while o_stall stays high.
module tlb_page_table_translator_core #(
    parameter int TLB_DEPTH   = 16,
    parameter int PAGE_COUNT  = 256,
    parameter int FRAME_COUNT = 256,
    parameter int OFFSET_BITS = 8
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    output logic                              o_stall,
    input  logic [tlbpt_pkg::ADDR_W-1:0]      i_logical_address,
    output logic                              o_valid,
    input  logic                              i_stall,
    output logic [tlbpt_pkg::ADDR_W-1:0]      o_physical_address,
    output logic [tlbpt_pkg::FRAME_OUT_W-1:0] o_frame_index,
    output logic                              o_tlb_hit,
    output logic                              o_page_fault,
    output logic [tlbpt_pkg::CNT_W-1:0]       o_fault_count,
    output logic [tlbpt_pkg::CNT_W-1:0]       o_hit_count
);

    tlbpt_pkg::t_ctrl_cmd cmd;
    tlbpt_pkg::t_ctrl_sts sts;

    tlbpt_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_sts   (sts),
        .o_cmd   (cmd)
    );

    tlbpt_dpath #(
        .TLB_DEPTH   (TLB_DEPTH),
        .PAGE_COUNT  (PAGE_COUNT),
        .FRAME_COUNT (FRAME_COUNT),
        .OFFSET_BITS (OFFSET_BITS)
    ) u_dpath (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cmd              (cmd),
        .o_sts              (sts),
        .i_logical_address  (i_logical_address),
        .i_out_stall        (i_stall),
        .o_out_valid        (o_valid),
        .o_physical_address (o_physical_address),
        .o_frame_index      (o_frame_index),
        .o_tlb_hit          (o_tlb_hit),
        .o_page_fault       (o_page_fault),
        .o_fault_count      (o_fault_count),
        .o_hit_count        (o_hit_count)
    );

endmodule

// ===== tb/tb_tlb_page_table_translator_core.sv =====
module tb_tlb_page_table_translator_core;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int TLB_DEPTH   = 16;
    localparam int PAGE_COUNT  = 256;
    localparam int FRAME_COUNT = 256;
    localparam int OFFSET_BITS = 8;
    localparam int PAGE_W      = $clog2(PAGE_COUNT);
    localparam int SLOT_W      = $clog2(TLB_DEPTH);

    localparam int N_RANDOM    = 826;

    typedef struct {
        logic [tlbpt_pkg::ADDR_W-1:0] addr;
        int unsigned                  gap;
    } t_addr_word;

    typedef struct packed {
        logic [tlbpt_pkg::ADDR_W-1:0]      phys;
        logic [tlbpt_pkg::FRAME_OUT_W-1:0] frame;
        logic                              hit;
        logic                              fault;
        logic [tlbpt_pkg::CNT_W-1:0]       faults;
        logic [tlbpt_pkg::CNT_W-1:0]       hits;
    } t_xlat;

    logic                              i_clk = 1'b0;
    logic                              i_rst_n = 1'b0;
    logic                              i_valid = 1'b0;
    logic                              o_stall;
    logic [tlbpt_pkg::ADDR_W-1:0]      i_logical_address = '0;
    logic                              o_valid;
    logic                              i_stall = 1'b0;
    logic [tlbpt_pkg::ADDR_W-1:0]      o_physical_address;
    logic [tlbpt_pkg::FRAME_OUT_W-1:0] o_frame_index;
    logic                              o_tlb_hit;
    logic                              o_page_fault;
    logic [tlbpt_pkg::CNT_W-1:0]       o_fault_count;
    logic [tlbpt_pkg::CNT_W-1:0]       o_hit_count;

    // translation state mirrored on the testbench side
    logic [PAGE_W-1:0]           tlb_page_tag [TLB_DEPTH];
    logic [7:0]                  tlb_frame_no [TLB_DEPTH];
    bit                          tlb_live [TLB_DEPTH];
    logic [SLOT_W-1:0]           fifo_slot = '0;
    logic [7:0]                  pt_frame [PAGE_COUNT];
    bit                          pt_mapped [PAGE_COUNT];
    logic [7:0]                  frame_cursor = '0;
    logic [tlbpt_pkg::CNT_W-1:0] fault_total = '0;
    logic [tlbpt_pkg::CNT_W-1:0] hit_total = '0;

    t_addr_word             addr_words [$];
    t_xlat                  expected_xlat [$];
    int                     words_total = 0;
    int                     words_accepted = 0;
    int                     results_seen = 0;
    int                     mismatches = 0;
    int                     idle_cnt = 0;
    int                     stall_left = 0;
    bit                     frame_wrapped = 1'b0;

    always #4 i_clk = ~i_clk;

    tlb_page_table_translator_core #(
        .TLB_DEPTH   (TLB_DEPTH),
        .PAGE_COUNT  (PAGE_COUNT),
        .FRAME_COUNT (FRAME_COUNT),
        .OFFSET_BITS (OFFSET_BITS)
    ) u_top (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_valid            (i_valid),
        .o_stall            (o_stall),
        .i_logical_address  (i_logical_address),
        .o_valid            (o_valid),
        .i_stall            (i_stall),
        .o_physical_address (o_physical_address),
        .o_frame_index      (o_frame_index),
        .o_tlb_hit          (o_tlb_hit),
        .o_page_fault       (o_page_fault),
        .o_fault_count      (o_fault_count),
        .o_hit_count        (o_hit_count)
    );

    // tlb lookup, then page table, then fault with fifo refill
    function automatic void translate_word(input logic [tlbpt_pkg::ADDR_W-1:0] addr);
        logic [PAGE_W-1:0]      pg;
        logic [OFFSET_BITS-1:0] off;
        logic [7:0]             frm;
        logic                   hit;
        logic                   flt;
        t_xlat                  r;
        pg  = addr[OFFSET_BITS +: PAGE_W];
        off = addr[OFFSET_BITS-1:0];
        frm = '0;
        hit = 1'b0;
        flt = 1'b0;
        for (int k = 0; k < TLB_DEPTH; k++) begin
            if (!hit && tlb_live[k] && tlb_page_tag[k] == pg) begin
                hit = 1'b1;
                frm = tlb_frame_no[k];
            end
        end
        if (hit) begin
            if (hit_total != tlbpt_pkg::CNT_MAX) hit_total++;
        end else if (pt_mapped[pg]) begin
            frm = pt_frame[pg];
        end else begin
            flt = 1'b1;
            if (fault_total != tlbpt_pkg::CNT_MAX) fault_total++;
            frm = frame_cursor;
            if (frame_cursor == FRAME_COUNT - 1) frame_wrapped = 1'b1;
            frame_cursor = 8'((frame_cursor + 1) % FRAME_COUNT);
            pt_frame[pg]  = frm;
            pt_mapped[pg] = 1'b1;
            tlb_page_tag[fifo_slot] = pg;
            tlb_frame_no[fifo_slot] = frm;
            tlb_live[fifo_slot]     = 1'b1;
            fifo_slot = SLOT_W'((fifo_slot + 1) % TLB_DEPTH);
        end
        r.phys   = tlbpt_pkg::ADDR_W'((32'(frm) << OFFSET_BITS) + 32'(off));
        r.frame  = frm;
        r.hit    = hit;
        r.fault  = flt;
        r.faults = fault_total;
        r.hits   = hit_total;
        expected_xlat.push_back(r);
    endfunction

    task automatic queue_word(input logic [tlbpt_pkg::ADDR_W-1:0] addr,
                              input int unsigned gap);
        t_addr_word w;
        w.addr = addr;
        w.gap  = gap;
        addr_words.push_back(w);
        words_total++;
    endtask

    // driver: one address word per handshake, gap drawn per word
    always @(posedge i_clk) begin : addr_drv
        t_addr_word nxt;
        if (!i_rst_n) begin
            i_valid <= 1'b0;
            idle_cnt = 0;
        end else begin
            if (i_valid && !o_stall) begin
                translate_word(i_logical_address);
                words_accepted++;
            end
            if (!i_valid || !o_stall) begin
                if (addr_words.size() > 0 && idle_cnt >= addr_words[0].gap) begin
                    nxt = addr_words.pop_front();
                    i_logical_address <= nxt.addr;
                    i_valid <= 1'b1;
                    idle_cnt = 0;
                end else begin
                    i_valid <= 1'b0;
                    idle_cnt++;
                end
            end
        end
    end

    // monitor: compare each result word with the oldest prediction
    always @(posedge i_clk) begin : result_mon
        t_xlat got;
        t_xlat want;
        if (!i_rst_n) begin
            i_stall <= 1'b0;
            stall_left = 0;
        end else begin
            if (o_valid && !i_stall) begin
                got = '{o_physical_address, o_frame_index, o_tlb_hit, o_page_fault,
                        o_fault_count, o_hit_count};
                if (expected_xlat.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("[%0t] result word with nothing pending: phys %h frame %h",
                                 $realtime, got.phys, got.frame);
                end else begin
                    want = expected_xlat.pop_front();
                    if (got !== want) begin
                        mismatches++;
                        if (mismatches <= 10) begin
                            $display("[%0t] mismatch on result %0d", $realtime, results_seen);
                            $display("  exp phys %h frame %h hit %b fault %b faults %0d hits %0d",
                                     want.phys, want.frame, want.hit, want.fault,
                                     want.faults, want.hits);
                            $display("  got phys %h frame %h hit %b fault %b faults %0d hits %0d",
                                     got.phys, got.frame, got.hit, got.fault,
                                     got.faults, got.hits);
                        end
                    end
                end
                results_seen++;
                // every so often a stretch with no back-pressure
                stall_left = ((results_seen % 200) >= 160) ? 0 : $urandom_range(0, 4);
            end else if (stall_left > 0) begin
                stall_left--;
            end
            i_stall <= (stall_left > 0);
        end
    end

    initial begin : stim
        logic [PAGE_W-1:0] fresh [PAGE_COUNT];
        logic [PAGE_W-1:0] recent [$];
        logic [PAGE_W-1:0] pg;
        logic [PAGE_W-1:0] tmp;
        int                fresh_n;
        int                j;
        int                r;
        int                n_mapped;
        int unsigned       gap;

        // directed: address extremes, tlb hit, eviction, page table hit without refill
        queue_word(16'h0000, $urandom_range(0, 4));
        queue_word(16'h0000, $urandom_range(0, 4));
        queue_word(16'hFFFF, $urandom_range(0, 4));
        queue_word(16'hFF00, $urandom_range(0, 4));
        queue_word(16'h00FF, $urandom_range(0, 4));
        for (int p = 1; p <= 16; p++) begin
            queue_word({8'(p), (p % 2) ? 8'hAA : 8'h55}, $urandom_range(0, 4));
        end
        // pages 0 and 255 are out of the tlb by now
        queue_word(16'h0080, $urandom_range(0, 4));
        queue_word(16'h0081, $urandom_range(0, 4));
        queue_word(16'hFF7F, $urandom_range(0, 4));

        for (int k = 0; k < PAGE_COUNT; k++) fresh[k] = PAGE_W'(k);
        for (int k = PAGE_COUNT - 1; k > 0; k--) begin
            j = $urandom_range(0, k);
            tmp = fresh[k];
            fresh[k] = fresh[j];
            fresh[j] = tmp;
        end
        fresh_n = 0;

        // random mix: new pages, recently faulted pages, anything
        for (int i = 0; i < N_RANDOM; i++) begin
            r = $urandom_range(0, 99);
            if (r < 45 && fresh_n < PAGE_COUNT) begin
                pg = fresh[fresh_n];
                fresh_n++;
                recent.push_back(pg);
                if (recent.size() > TLB_DEPTH) void'(recent.pop_front());
            end else if (r < 75 && recent.size() > 0) begin
                pg = recent[$urandom_range(0, recent.size() - 1)];
            end else begin
                pg = PAGE_W'($urandom_range(0, PAGE_COUNT - 1));
            end
            gap = ((i / 64) % 5 == 4) ? 0 : $urandom_range(0, 4);
            queue_word({pg, 8'($urandom)}, gap);
        end

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (words_accepted != words_total || expected_xlat.size() != 0) @(negedge i_clk);
        repeat (8) @(negedge i_clk);

        n_mapped = 0;
        for (int k = 0; k < PAGE_COUNT; k++) n_mapped += pt_mapped[k];
        $display("%0d address words translated, %0d results checked, %0d mismatches",
                 words_accepted, results_seen, mismatches);
        $display("%0d faults, %0d of %0d pages mapped, frame wrap %0s, hit total %0d%0s",
                 fault_total, n_mapped, PAGE_COUNT, frame_wrapped ? "seen" : "not seen",
                 hit_total, (hit_total == tlbpt_pkg::CNT_MAX) ? " (saturated)" : "");
        if (mismatches == 0 && expected_xlat.size() == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

    initial begin : watchdog
        #30_000_000;
        $display("Test completed with failures");
        $finish;
    end

endmodule
